@@ rtl/core/mrf_pkg.sv @@
package mrf_pkg;

	// Default sizing
	localparam int HISTORY_DEPTH = 4;
	localparam int MAX_PDU       = 253;

	// CRC-16 (reflected) and frame constants
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [8:0]  COUNT_MAX = 9'd511;
	localparam logic [8:0]  MIN_FRAME = 9'd4;

	// Result queue
	localparam int FIFO_DEPTH = 4;

	typedef enum logic [1:0] {
		REQ_START = 2'd0,
		REQ_BYTE  = 2'd1,
		REQ_READ  = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		V_OK        = 4'd0,
		V_RUNT      = 4'd1,
		V_CRC       = 4'd2,
		V_ADDRESS   = 4'd3,
		V_EXCEPTION = 4'd4,
		V_FUNCTION  = 4'd5,
		V_SIZE      = 4'd6,
		V_DUPLICATE = 4'd7,
		V_READ      = 4'd8
	} verdict_t;

	// Classified item handed from front to back
	typedef struct packed {
		logic        valid;
		req_t        kind;
		logic        has_result;
		logic        last;
		logic        near;
		logic [6:0]  want_fc;
		logic [7:0]  want_size;
		logic [8:0]  count;
		logic [15:0] crc;
		logic [7:0]  seen_addr;
		logic [7:0]  seen_fc;
		logic [7:0]  seen_third;
		logic        cmp_en;
		logic [7:0]  pos;
		logic [7:0]  data;
		logic [7:0]  idx;
	} item_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [7:0]  exc;
		logic [7:0]  pdu;
	} result_t;

	// One byte through the CRC, bit by bit
	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage

@@ rtl/core/mrf_front.sv @@
module mrf_front #(
	parameter int HISTORY_DEPTH = mrf_pkg::HISTORY_DEPTH,
	parameter int MAX_PDU       = mrf_pkg::MAX_PDU,
	localparam int SLOTS = HISTORY_DEPTH + 1,
	localparam int SW    = $clog2(SLOTS),
	localparam int AW    = $clog2(MAX_PDU)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [1:0]      req_type,
	input  logic [6:0]      function_code,
	input  logic [7:0]      expected_size,
	input  logic [7:0]      rx_byte,
	input  logic            frame_end,
	input  logic            near_deadline,
	input  logic [7:0]      read_index,
	input  logic [SW-1:0]   staging_slot,
	output mrf_pkg::item_t  item_s1,
	output logic [7:0]      rd_data_s1 [SLOTS]
);

	logic [15:0] crc_q;
	logic [8:0]  count_q;
	logic [6:0]  want_fc_q;
	logic [7:0]  want_size_q;
	logic [7:0]  seen_addr_q, seen_fc_q, seen_third_q;
	logic [7:0]  mem_q [SLOTS][MAX_PDU];

	mrf_pkg::req_t kind;
	logic [15:0] crc_n;
	logic [8:0]  count_n;
	logic [8:0]  rel;
	logic        store_en;
	logic        wr_en;
	logic [AW-1:0] rd_addr;
	mrf_pkg::item_t item_n;

	assign kind     = mrf_pkg::req_t'(req_type);
	assign crc_n    = mrf_pkg::crc_byte(crc_q, rx_byte);
	assign count_n  = (count_q < mrf_pkg::COUNT_MAX) ? count_q + 9'd1 : count_q;
	assign rel      = count_q - 9'd2;
	assign store_en = (count_q >= 9'd2) && (rel < {1'b0, want_size_q}) &&
		(rel < 9'(MAX_PDU));
	assign wr_en    = accept && (kind == mrf_pkg::REQ_BYTE) && store_en;
	assign rd_addr  = (kind == mrf_pkg::REQ_READ) ? read_index[AW-1:0] : rel[AW-1:0];

	// Classify the item and gather what the back needs
	always_comb begin
		item_n            = '0;
		item_n.kind       = kind;
		item_n.last       = frame_end;
		item_n.near       = near_deadline;
		item_n.want_fc    = want_fc_q;
		item_n.want_size  = want_size_q;
		item_n.count      = count_n;
		item_n.crc        = crc_n;
		item_n.seen_addr  = (count_q == 9'd0) ? rx_byte : seen_addr_q;
		item_n.seen_fc    = (count_q == 9'd1) ? rx_byte : seen_fc_q;
		item_n.seen_third = (count_q == 9'd2) ? rx_byte : seen_third_q;
		item_n.cmp_en     = store_en;
		item_n.pos        = rel[7:0];
		item_n.data       = rx_byte;
		item_n.idx        = read_index;
		case (kind)
			mrf_pkg::REQ_START: item_n.valid = accept;
			mrf_pkg::REQ_BYTE: begin
				item_n.valid      = accept;
				item_n.has_result = frame_end;
			end
			mrf_pkg::REQ_READ: begin
				item_n.valid      = accept;
				item_n.has_result = 1'b1;
			end
			default: item_n.valid = 1'b0;
		endcase
	end

	// Frame state: arm on start, advance per byte, clear at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q        <= mrf_pkg::CRC_INIT;
			count_q      <= '0;
			want_fc_q    <= '0;
			want_size_q  <= '0;
			seen_addr_q  <= '0;
			seen_fc_q    <= '0;
			seen_third_q <= '0;
		end else if (accept) begin
			if (kind == mrf_pkg::REQ_START || (kind == mrf_pkg::REQ_BYTE && frame_end)) begin
				crc_q        <= mrf_pkg::CRC_INIT;
				count_q      <= '0;
				seen_addr_q  <= '0;
				seen_fc_q    <= '0;
				seen_third_q <= '0;
				if (kind == mrf_pkg::REQ_START) begin
					want_fc_q   <= function_code;
					want_size_q <= expected_size;
				end
			end else if (kind == mrf_pkg::REQ_BYTE) begin
				crc_q        <= crc_n;
				count_q      <= count_n;
				seen_addr_q  <= item_n.seen_addr;
				seen_fc_q    <= item_n.seen_fc;
				seen_third_q <= item_n.seen_third;
			end
		end
	end

	// Hand the item over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else begin
			item_s1 <= item_n;
		end
	end

	// One PDU bank per slot: staging write, same-address read of every bank
	for (genvar b = 0; b < SLOTS; b++) begin : g_bank
		always_ff @(posedge clk) begin
			if (wr_en && staging_slot == SW'(b)) begin
				mem_q[b][rel[AW-1:0]] <= rx_byte;
			end
			rd_data_s1[b] <= mem_q[b][rd_addr];
		end
	end

endmodule

@@ rtl/core/mrf_back.sv @@
module mrf_back #(
	parameter int HISTORY_DEPTH = mrf_pkg::HISTORY_DEPTH,
	parameter int MAX_PDU       = mrf_pkg::MAX_PDU,
	localparam int SLOTS = HISTORY_DEPTH + 1,
	localparam int SW    = $clog2(SLOTS),
	localparam int HW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       slave_address,
	input  mrf_pkg::item_t   item_s1,
	input  logic [7:0]       rd_data_s1 [SLOTS],
	output logic [SW-1:0]    staging_slot,
	output logic             res_push,
	output mrf_pkg::result_t res_data
);

	logic [SW-1:0] slot_map_q [HISTORY_DEPTH];
	logic [SW-1:0] staging_q, accepted_q;
	logic [6:0]    hist_fc_q [HISTORY_DEPTH];
	logic [7:0]    hist_size_q [HISTORY_DEPTH];
	logic [HISTORY_DEPTH-1:0] hist_valid_q;
	logic [HW-1:0] hist_next_q;
	logic [HISTORY_DEPTH-1:0] match_q;

	logic [HISTORY_DEPTH-1:0] match_n;
	logic [HISTORY_DEPTH-1:0] dup_hit;
	logic [HW-1:0] last_ent;
	logic [HW-1:0] next_ent;
	logic          commit;
	logic          rd_ok;

	assign staging_slot = staging_q;
	assign last_ent = (hist_next_q == '0) ? HW'(HISTORY_DEPTH - 1) : hist_next_q - 1'b1;
	assign next_ent = (hist_next_q == HW'(HISTORY_DEPTH - 1)) ? '0 : hist_next_q + 1'b1;

	// Drop entries whose stored byte differs
	for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cmp
		assign match_n[i] = match_q[i] && (!item_s1.cmp_en ||
			(hist_valid_q[i] && item_s1.pos < hist_size_q[i] &&
			 rd_data_s1[slot_map_q[i]] == item_s1.data));
		assign dup_hit[i] = match_n[i] && hist_valid_q[i] &&
			hist_fc_q[i] == item_s1.want_fc && hist_size_q[i] == item_s1.want_size;
	end

	assign rd_ok = (accepted_q != staging_q) && (item_s1.idx < hist_size_q[last_ent]) &&
		({1'b0, item_s1.idx} < 9'(MAX_PDU));

	// Verdict, first failing check wins
	always_comb begin
		res_push = 1'b0;
		res_data = '0;
		commit   = 1'b0;
		if (item_s1.valid && item_s1.has_result) begin
			res_push = 1'b1;
			if (item_s1.kind == mrf_pkg::REQ_READ) begin
				res_data.verdict = mrf_pkg::V_READ;
				res_data.pdu     = rd_ok ? rd_data_s1[accepted_q] : 8'h00;
			end else if (item_s1.count < mrf_pkg::MIN_FRAME) begin
				res_data.verdict = mrf_pkg::V_RUNT;
			end else if (item_s1.crc != 16'h0000) begin
				res_data.verdict = mrf_pkg::V_CRC;
			end else if (item_s1.seen_addr != slave_address) begin
				res_data.verdict = mrf_pkg::V_ADDRESS;
			end else if (item_s1.seen_fc == {1'b1, item_s1.want_fc}) begin
				res_data.verdict = mrf_pkg::V_EXCEPTION;
				res_data.exc     = item_s1.seen_third;
			end else if (item_s1.seen_fc != {1'b0, item_s1.want_fc}) begin
				res_data.verdict = mrf_pkg::V_FUNCTION;
			end else if ({1'b0, item_s1.want_size} > 9'(MAX_PDU) ||
				item_s1.count != {1'b0, item_s1.want_size} + 9'd4) begin
				res_data.verdict = mrf_pkg::V_SIZE;
			end else if (!item_s1.near && (|dup_hit)) begin
				res_data.verdict = mrf_pkg::V_DUPLICATE;
			end else begin
				res_data.verdict = mrf_pkg::V_OK;
				commit           = 1'b1;
			end
		end
	end

	// Match flags: reset on start and frame end, narrow per byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= '1;
		end else if (item_s1.valid) begin
			unique case (item_s1.kind)
				mrf_pkg::REQ_START: match_q <= '1;
				mrf_pkg::REQ_BYTE:  match_q <= item_s1.last ? '1 : match_n;
				default:            match_q <= match_q;
			endcase
		end
	end

	// Rotate the accepted PDU into the history ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				slot_map_q[i]  <= SW'(i);
				hist_fc_q[i]   <= '0;
				hist_size_q[i] <= '0;
			end
			hist_valid_q <= '0;
			staging_q    <= SW'(HISTORY_DEPTH);
			accepted_q   <= SW'(HISTORY_DEPTH);
			hist_next_q  <= '0;
		end else if (commit) begin
			slot_map_q[hist_next_q]   <= staging_q;
			accepted_q                <= staging_q;
			staging_q                 <= slot_map_q[hist_next_q];
			hist_fc_q[hist_next_q]    <= item_s1.want_fc;
			hist_size_q[hist_next_q]  <= item_s1.want_size;
			hist_valid_q[hist_next_q] <= 1'b1;
			hist_next_q               <= next_ent;
		end
	end

endmodule

@@ rtl/core/mrf_fifo.sv @@
module mrf_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mrf_pkg::result_t wdata,
	input  logic             inflight,
	input  logic             pop,
	output logic             empty,
	output logic             full,
	output mrf_pkg::result_t rdata
);

	localparam int PW = $clog2(mrf_pkg::FIFO_DEPTH);

	mrf_pkg::result_t buf_q [mrf_pkg::FIFO_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;
	logic          do_pop;

	assign empty  = (cnt_q == '0);
	assign do_pop = pop && !empty;
	assign rdata  = buf_q[rd_q];
	// Hold off input while the queue could not take every result in flight
	assign full   = ({1'b0, cnt_q} + {{PW+1{1'b0}}, inflight}) >= (PW+2)'(mrf_pkg::FIFO_DEPTH - 1);

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + {{PW{1'b0}}, push} - {{PW{1'b0}}, do_pop};
		end
	end

endmodule

@@ rtl/core/modbus_rtu_response_filter.sv @@
// Modbus RTU response filter. A start item arms the expected function code and
// PDU size; frame bytes then stream in, one per cycle unless full, with no gaps
// needed, and the block keeps the CRC-16, byte count and duplicate match state
// as they arrive. On the byte flagged frame_end one verdict is queued; a read
// item queues the requested byte of the last accepted PDU. The block takes one
// item every cycle unless full; a result passes the item register, then the
// result queue, to the output. The front stage updates the CRC and issues one
// read of every PDU bank per cycle; the result queue holds three results, and
// full rises early enough that nothing in flight is lost. PDU banks are not
// cleared after reset; only entries already written are read.
module modbus_rtu_response_filter #(
	parameter int HISTORY_DEPTH = mrf_pkg::HISTORY_DEPTH,
	parameter int MAX_PDU       = mrf_pkg::MAX_PDU
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] req_type,
	input  logic [6:0] function_code,
	input  logic [7:0] expected_size,
	input  logic [7:0] rx_byte,
	input  logic       frame_end,
	input  logic       near_deadline,
	input  logic [7:0] read_index,
	output logic       empty,
	input  logic       pop,
	output logic [3:0] verdict,
	output logic [7:0] exception_code,
	output logic [7:0] pdu_byte,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	localparam int SLOTS = HISTORY_DEPTH + 1;
	localparam int SW    = $clog2(SLOTS);

	logic             accept;
	logic [7:0]       slave_address_q;
	mrf_pkg::item_t   item_s1;
	logic [7:0]       rd_data_s1 [SLOTS];
	logic [SW-1:0]    staging_slot;
	logic             res_push;
	mrf_pkg::result_t res_data;
	mrf_pkg::result_t head;

	assign accept    = push && !full;
	assign cfg_ready = 1'b1;

	// Address register, one beat per write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= 8'd1;
		end else if (cfg_valid && cfg_ready) begin
			slave_address_q <= cfg_data;
		end
	end

	mrf_front #(.HISTORY_DEPTH(HISTORY_DEPTH), .MAX_PDU(MAX_PDU)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.req_type      (req_type),
		.function_code (function_code),
		.expected_size (expected_size),
		.rx_byte       (rx_byte),
		.frame_end     (frame_end),
		.near_deadline (near_deadline),
		.read_index    (read_index),
		.staging_slot  (staging_slot),
		.item_s1       (item_s1),
		.rd_data_s1    (rd_data_s1)
	);

	mrf_back #(.HISTORY_DEPTH(HISTORY_DEPTH), .MAX_PDU(MAX_PDU)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.slave_address (slave_address_q),
		.item_s1       (item_s1),
		.rd_data_s1    (rd_data_s1),
		.staging_slot  (staging_slot),
		.res_push      (res_push),
		.res_data      (res_data)
	);

	mrf_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_push),
		.wdata    (res_data),
		.inflight (item_s1.valid && item_s1.has_result),
		.pop      (pop),
		.empty    (empty),
		.full     (full),
		.rdata    (head)
	);

	assign verdict        = head.verdict;
	assign exception_code = head.exc;
	assign pdu_byte       = head.pdu;

endmodule

@@ sim/mrf_checker.sv @@
module mrf_checker
	import mrf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [1:0] req_type,
	input  logic [6:0] function_code,
	input  logic [7:0] expected_size,
	input  logic [7:0] rx_byte,
	input  logic       frame_end,
	input  logic       near_deadline,
	input  logic [7:0] read_index,
	input  logic       empty,
	input  logic       pop,
	input  logic [3:0] verdict,
	input  logic [7:0] exception_code,
	input  logic [7:0] pdu_byte,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [7:0] cfg_data,
	output int         fails,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NH = HISTORY_DEPTH;
	localparam int NP = MAX_PDU;

	typedef struct {
		verdict_t   v;
		logic [7:0] exc;
		logic [7:0] pdu;
	} outcome_t;

	outcome_t    outcomes_due[$];

	// Mirror of the filter state
	logic [7:0]  addr_reg = 8'd1;
	logic [15:0] crc_run = CRC_INIT;
	logic [8:0]  nbytes = '0;
	logic [6:0]  armed_fc = '0;
	logic [7:0]  armed_size = '0;
	logic [7:0]  b_addr = '0, b_fc = '0, b_third = '0;
	logic [7:0]  bank [0:NH][0:NP-1];
	int          bank_of [0:NH-1];
	int          stage_bank = NH;
	int          last_bank = NH;
	logic [6:0]  h_fc [0:NH-1];
	logic [7:0]  h_size [0:NH-1];
	logic        h_valid [0:NH-1];
	int          h_wr = 0;
	logic [NH-1:0] still_same = '1;

	initial begin
		for (int i = 0; i < NH; i++) begin
			bank_of[i] = i;
			h_fc[i] = '0;
			h_size[i] = '0;
			h_valid[i] = 1'b0;
		end
	end

	assign pending = outcomes_due.size();

	function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
		return r;
	endfunction

	task automatic restart_frame();
		crc_run = CRC_INIT;
		nbytes = '0;
		b_addr = '0;
		b_fc = '0;
		b_third = '0;
		still_same = '1;
	endtask

	// Absorb one frame byte: CRC, captured header bytes and history match
	task automatic absorb(logic [7:0] b);
		int pos;
		int p;
		pos = nbytes;
		crc_run = crc_step(crc_run, b);
		if (pos == 0) b_addr = b;
		if (pos == 1) b_fc = b;
		if (pos == 2) b_third = b;
		if (pos >= 2 && pos - 2 < armed_size && pos - 2 < NP) begin
			p = pos - 2;
			bank[stage_bank][p] = b;
			for (int i = 0; i < NH; i++)
				if (!(h_valid[i] && p < h_size[i] && bank[bank_of[i]][p] == b))
					still_same[i] = 1'b0;
		end
		if (nbytes < COUNT_MAX) nbytes++;
	endtask

	function automatic verdict_t frame_verdict(logic nr, output logic [7:0] exc);
		int old;
		exc = '0;
		if (nbytes < MIN_FRAME) return V_RUNT;
		if (crc_run != 16'h0) return V_CRC;
		if (b_addr != addr_reg) return V_ADDRESS;
		if (b_fc == {1'b1, armed_fc}) begin
			exc = b_third;
			return V_EXCEPTION;
		end
		if (b_fc != {1'b0, armed_fc}) return V_FUNCTION;
		if (armed_size > NP || nbytes != armed_size + 9'd4) return V_SIZE;
		if (!nr)
			for (int i = 0; i < NH; i++)
				if (still_same[i] && h_valid[i] && h_fc[i] == armed_fc &&
						h_size[i] == armed_size)
					return V_DUPLICATE;
		// Promote the staging bank into the history ring
		old = bank_of[h_wr];
		bank_of[h_wr] = stage_bank;
		last_bank = stage_bank;
		stage_bank = old;
		h_fc[h_wr] = armed_fc;
		h_size[h_wr] = armed_size;
		h_valid[h_wr] = 1'b1;
		h_wr = (h_wr + 1) % NH;
		return V_OK;
	endfunction

	// Predict on every accepted input beat
	always @(posedge clk) begin
		outcome_t o;
		int lst;
		if (arst_n && cfg_valid && cfg_ready) addr_reg <= cfg_data;
		if (arst_n && push && !full) begin
			case (req_t'(req_type))
				REQ_START: begin
					armed_fc = function_code;
					armed_size = expected_size;
					restart_frame();
				end
				REQ_BYTE: begin
					absorb(rx_byte);
					if (frame_end) begin
						o.v = frame_verdict(near_deadline, o.exc);
						o.pdu = '0;
						outcomes_due.push_back(o);
						restart_frame();
					end
				end
				REQ_READ: begin
					o.v = V_READ;
					o.exc = '0;
					o.pdu = '0;
					if (last_bank != stage_bank && last_bank <= NH) begin
						lst = (h_wr + NH - 1) % NH;
						if (read_index < h_size[lst] && read_index < NP)
							o.pdu = bank[last_bank][read_index];
					end
					outcomes_due.push_back(o);
				end
				default: ;
			endcase
		end
	end

	// Compare every popped result beat against the oldest prediction
	always @(posedge clk) begin
		outcome_t o;
		if (arst_n && pop && !empty) begin
			if (outcomes_due.size() == 0) begin
				$error("unexpected result beat: verdict %0d", verdict);
				fails++;
			end else begin
				o = outcomes_due.pop_front();
				if (verdict !== o.v) begin
					$error("verdict: expected %0d, got %0d", o.v, verdict);
					fails++;
				end
				if (exception_code !== o.exc) begin
					$error("exception_code: expected %0d, got %0d", o.exc, exception_code);
					fails++;
				end
				if (pdu_byte !== o.pdu) begin
					$error("pdu_byte: expected %0d, got %0d", o.pdu, pdu_byte);
					fails++;
				end
			end
		end
	end

endmodule

@@ sim/tb.sv @@
module tb;
	import mrf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [1:0] req_type = REQ_NONE;
	logic [6:0] function_code = '0;
	logic [7:0] expected_size = '0;
	logic [7:0] rx_byte = '0;
	logic       frame_end = 1'b0;
	logic       near_deadline = 1'b0;
	logic [7:0] read_index = '0;
	logic       empty;
	logic       pop = 1'b0;
	logic [3:0] verdict;
	logic [7:0] exception_code;
	logic [7:0] pdu_byte;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = '0;
	int         fails;
	int         pending;

	typedef enum int {
		F_GOOD, F_EXCEPTION, F_BADCRC, F_BADADDR, F_BADFC, F_BADSIZE, F_RUNT, F_REPEAT
	} frame_kind_t;

	logic [7:0] station = 8'd1;
	logic [6:0] prev_fc = '0;
	logic [7:0] prev_size = '0;
	logic [7:0] prev_pdu [$];
	int         beats_sent = 0;
	int         burst_left = 0;
	int         rx_cycle = 0;
	int         rx_hold = 0;

	modbus_rtu_response_filter dut (
		.clk, .arst_n, .push, .full, .req_type, .function_code, .expected_size,
		.rx_byte, .frame_end, .near_deadline, .read_index, .empty, .pop,
		.verdict, .exception_code, .pdu_byte, .cfg_valid, .cfg_ready, .cfg_data
	);

	mrf_checker u_chk (
		.clk, .arst_n, .push, .full, .req_type, .function_code, .expected_size,
		.rx_byte, .frame_end, .near_deadline, .read_index, .empty, .pop,
		.verdict, .exception_code, .pdu_byte, .cfg_valid, .cfg_ready, .cfg_data,
		.fails, .pending
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end

	// Receiver: stall pattern that shifts with rx_cycle bits 11:10, with a long hold now and then
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_hold > 0) begin
			pop <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else if (rx_cycle % 3000 == 1500) begin
			pop <= 1'b0;
			rx_hold <= 200;
		end else begin
			case (rx_cycle[11:10])
				2'd0: pop <= 1'b1;
				2'd1: pop <= $urandom_range(0, 1);
				2'd2: pop <= ($urandom_range(0, 9) < 8);
				default: pop <= ($urandom_range(0, 9) < 2);
			endcase
		end
	end

	function automatic logic [15:0] crc16(logic [7:0] q [$]);
		logic [15:0] c;
		c = 16'hFFFF;
		foreach (q[i]) begin
			c ^= {8'h00, q[i]};
			for (int k = 0; k < 8; k++)
				c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		end
		return c;
	endfunction

	// Offer one beat, in bursts with random gaps, and hold it until taken
	task automatic put(req_t k, logic [6:0] fc, logic [7:0] sz, logic [7:0] b,
			logic fe, logic nr, logic [7:0] idx);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		push <= 1'b1;
		req_type <= k;
		function_code <= fc;
		expected_size <= sz;
		rx_byte <= b;
		frame_end <= fe;
		near_deadline <= nr;
		read_index <= idx;
		@(posedge clk);
		while (full) @(posedge clk);
		if (k != REQ_NONE) beats_sent++;
	endtask

	task automatic arm(logic [6:0] fc, logic [7:0] sz);
		put(REQ_START, fc, sz, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic send_bytes(logic [7:0] q [$], logic nr);
		foreach (q[i])
			put(REQ_BYTE, $urandom, $urandom, q[i], i == q.size() - 1,
				(i == q.size() - 1) ? nr : 1'($urandom), $urandom);
	endtask

	task automatic read_back(logic [7:0] idx);
		put(REQ_READ, $urandom, $urandom, $urandom, $urandom, $urandom, idx);
	endtask

	// Wait for every outstanding result, then let the pipeline settle
	task automatic drain();
		push <= 1'b0;
		burst_left = 0;
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_station(logic [7:0] a);
		cfg_valid <= 1'b1;
		cfg_data <= a;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		station = a;
	endtask

	function automatic logic [7:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) return $urandom_range(0, 8);
		if (r < 93) return $urandom_range(9, 40);
		if (r < 98) return $urandom_range(200, 253);
		return $urandom_range(254, 255);
	endfunction

	// Arm and send one response frame of the given kind
	task automatic run_frame(frame_kind_t kind, logic nr);
		logic [7:0]  q [$];
		logic [7:0]  body [$];
		logic [6:0]  fc;
		logic [7:0]  sz;
		logic [15:0] c;
		int          n;
		fc = $urandom;
		sz = pick_size();
		if (kind == F_REPEAT) begin
			fc = prev_fc;
			sz = prev_size;
			body = prev_pdu;
		end else begin
			n = sz;
			if (kind == F_BADSIZE)
				n = (sz > 0 && $urandom_range(0, 1)) ? sz - 1 : sz + 1;
			for (int i = 0; i < n; i++) body.push_back($urandom);
		end
		arm(fc, sz);
		if (kind == F_RUNT) begin
			n = $urandom_range(1, 3);
			for (int i = 0; i < n; i++) q.push_back($urandom);
			send_bytes(q, nr);
			return;
		end
		q.push_back(kind == F_BADADDR ? station ^ 8'($urandom_range(1, 255)) : station);
		if (kind == F_EXCEPTION) begin
			q.push_back({1'b1, fc});
			q.push_back($urandom);
		end else begin
			q.push_back(kind == F_BADFC ? {1'b0, fc + 7'($urandom_range(1, 127))}
				: {1'b0, fc});
			foreach (body[i]) q.push_back(body[i]);
		end
		c = crc16(q);
		if (kind == F_BADCRC) c ^= 16'(1) << $urandom_range(0, 15);
		q.push_back(c[7:0]);
		q.push_back(c[15:8]);
		send_bytes(q, nr);
		if (kind == F_GOOD && sz <= 253) begin
			prev_fc = fc;
			prev_size = sz;
			prev_pdu = body;
		end
	endtask

	initial begin
		logic [7:0]  q [$];
		logic [15:0] c;
		int          r;
		logic [7:0]  station_plan [4];

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: read with nothing accepted, unarmed frame, unused request
		read_back(8'd0);
		q = '{8'd1, 8'd0};
		c = crc16(q);
		q.push_back(c[7:0]);
		q.push_back(c[15:8]);
		send_bytes(q, 1'b0);
		read_back(8'd0);
		put(REQ_NONE, 7'h7F, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF);

		// Directed: one of each verdict, duplicate with and without deadline skip
		run_frame(F_GOOD, 1'b0);
		read_back(8'd0);
		read_back(8'd255);
		run_frame(F_REPEAT, 1'b0);
		run_frame(F_REPEAT, 1'b1);
		run_frame(F_EXCEPTION, 1'b0);
		run_frame(F_RUNT, 1'b0);
		run_frame(F_BADCRC, 1'b0);
		run_frame(F_BADADDR, 1'b0);
		run_frame(F_BADFC, 1'b0);
		run_frame(F_BADSIZE, 1'b0);
		arm(7'h7F, 8'd255);
		q = '{8'd1, 8'h7F};
		for (int i = 0; i < 255; i++) q.push_back(8'hFF);
		c = crc16(q);
		q.push_back(c[7:0]);
		q.push_back(c[15:8]);
		send_bytes(q, 1'b1);
		drain();

		// Random phases, each under its own station address
		station_plan = '{8'd0, 8'd255, 8'($urandom), 8'd1};
		for (int ph = 0; ph < 4; ph++) begin
			set_station(station_plan[ph]);
			while (beats_sent < 450 * (ph + 1) + 50) begin
				r = $urandom_range(0, 99);
				if (r < 40) run_frame(F_GOOD, $urandom_range(0, 3) == 0);
				else if (r < 50) run_frame(F_REPEAT, $urandom_range(0, 3) == 0);
				else if (r < 70) read_back($urandom_range(0, 3) == 0 ? 8'($urandom)
					: 8'($urandom_range(0, prev_size + 1)));
				else if (r < 90) run_frame(frame_kind_t'($urandom_range(1, 6)),
					$urandom_range(0, 1));
				else if (r < 95) begin
					q = {};
					r = $urandom_range(1, 6);
					for (int i = 0; i < r; i++) q.push_back($urandom);
					send_bytes(q, $urandom_range(0, 1));
				end else if (r < 99) put(REQ_NONE, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom);
				else drain();
			end
			if (ph == 1) begin
				// Overlong frame that saturates the byte count
				arm($urandom, 8'd8);
				q = {};
				for (int i = 0; i < 520; i++) q.push_back($urandom);
				send_bytes(q, 1'b0);
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (fails == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/mrf_pkg.sv
rtl/core/mrf_front.sv
rtl/core/mrf_back.sv
rtl/core/mrf_fifo.sv
rtl/core/modbus_rtu_response_filter.sv
sim/mrf_checker.sv
sim/tb.sv
